FILE: src/asw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_pkg
// Shared types and constants for the ADC settling window detector.
// ----------------------------------------------------------------------------
package asw_pkg;

   localparam int WINDOW_LEN = 8;
   localparam int POS_W      = $clog2(WINDOW_LEN);
   localparam int CNT_W      = 24;
   localparam int DATA_W     = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DATA_W-1:0] FRAME_BASE = 16'h1000;
   localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

   localparam logic [DATA_W-1:0] RST_STABLE_RANGE   = 16'd16;
   localparam logic [DATA_W-1:0] RST_STABLE_WINDOWS = 16'd4;
   localparam logic [DATA_W-1:0] RST_TIMEOUT        = 16'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_RANGE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_WINDOWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT        = 2'd2;

   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_IGNORED = 2'd2
   } kind_type;

   typedef struct packed {
      logic              req_type;
      logic [3:0]        channel;
      logic [7:0]        multiplier;
      logic [DATA_W-1:0] sample;
      logic              transfer_ok;
   } req_word_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] command_frame;
      logic [DATA_W-1:0] value;
      logic              unstable;
   } rsp_word_type;

endpackage

FILE: src/asw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_core
// Run state, window min/max tracking and end-of-run decision for one word.
// ----------------------------------------------------------------------------
module asw_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [asw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [asw_pkg::DATA_W-1:0]          csr_write_data,
   input  logic                                accept,
   input  asw_pkg::req_word_type               req_word,
   output asw_pkg::rsp_word_type               rsp_word
);

   logic [asw_pkg::DATA_W-1:0] stable_range_ff;
   logic [asw_pkg::DATA_W-1:0] stable_windows_ff;
   logic [asw_pkg::DATA_W-1:0] timeout_samples_ff;

   logic                       busy_ff, busy_in;
   logic [asw_pkg::DATA_W-1:0] frame_ff, frame_in;
   logic [asw_pkg::DATA_W-1:0] max_ff, max_in;
   logic [asw_pkg::DATA_W-1:0] min_ff, min_in;
   logic [asw_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [asw_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [asw_pkg::CNT_W-1:0]  run_ff, run_in;
   logic [asw_pkg::CNT_W-1:0]  stable_tgt_ff, stable_tgt_in;
   logic [asw_pkg::CNT_W-1:0]  timeout_tgt_ff, timeout_tgt_in;

   logic [7:0]                 mul_eff;
   logic [asw_pkg::CNT_W-1:0]  idx_inc;
   logic [asw_pkg::POS_W-1:0]  pos_inc;
   logic [asw_pkg::DATA_W-1:0] max_upd, min_upd, spread;
   logic [asw_pkg::CNT_W-1:0]  run_upd;
   logic                       win_first, win_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_range_ff    <= asw_pkg::RST_STABLE_RANGE;
         stable_windows_ff  <= asw_pkg::RST_STABLE_WINDOWS;
         timeout_samples_ff <= asw_pkg::RST_TIMEOUT;
      end else if (csr_write_enable) begin
         case (csr_index)
            asw_pkg::CSR_STABLE_RANGE:   stable_range_ff    <= csr_write_data;
            asw_pkg::CSR_STABLE_WINDOWS: stable_windows_ff  <= csr_write_data;
            asw_pkg::CSR_TIMEOUT:        timeout_samples_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mul_eff   = (req_word.multiplier == 8'd0) ? 8'd1 : req_word.multiplier;
      idx_inc   = idx_ff + asw_pkg::CNT_W'(1);
      win_first = (pos_ff == asw_pkg::POS_W'(1));
      win_last  = (idx_ff != '0) && (pos_ff == '0);

      if (idx_inc == '0 || pos_ff == asw_pkg::POS_W'(asw_pkg::WINDOW_LEN - 1)) begin
         pos_inc = '0;
      end else begin
         pos_inc = pos_ff + asw_pkg::POS_W'(1);
      end

      if (win_first) begin
         max_upd = req_word.sample;
         min_upd = req_word.sample;
      end else begin
         max_upd = (req_word.sample > max_ff) ? req_word.sample : max_ff;
         min_upd = (req_word.sample < min_ff) ? req_word.sample : min_ff;
      end
      spread = max_upd - min_upd;

      run_upd = run_ff;
      if (win_last) begin
         if (spread < stable_range_ff) begin
            if (run_ff != asw_pkg::CNT_MAX) begin
               run_upd = run_ff + asw_pkg::CNT_W'(1);
            end
         end else begin
            run_upd = '0;
         end
      end

      busy_in        = busy_ff;
      frame_in       = frame_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      run_in         = run_ff;
      stable_tgt_in  = stable_tgt_ff;
      timeout_tgt_in = timeout_tgt_ff;

      rsp_word.kind          = asw_pkg::KIND_IGNORED;
      rsp_word.command_frame = '0;
      rsp_word.value         = '0;
      rsp_word.unstable      = 1'b0;

      if (req_word.req_type == asw_pkg::REQ_START) begin
         frame_in       = asw_pkg::FRAME_BASE | (asw_pkg::DATA_W'(req_word.channel) << 7);
         max_in         = '0;
         min_in         = '0;
         idx_in         = '0;
         pos_in         = '0;
         run_in         = '0;
         stable_tgt_in  = asw_pkg::CNT_W'(mul_eff) * asw_pkg::CNT_W'(stable_windows_ff);
         timeout_tgt_in = asw_pkg::CNT_W'(mul_eff) * asw_pkg::CNT_W'(timeout_samples_ff);
         if (stable_windows_ff == '0) begin
            busy_in       = 1'b0;
            rsp_word.kind = asw_pkg::KIND_DONE;
         end else begin
            busy_in                = 1'b1;
            rsp_word.kind          = asw_pkg::KIND_FRAME;
            rsp_word.command_frame = frame_in;
         end
      end else if (busy_ff) begin
         if (!req_word.transfer_ok) begin
            busy_in           = 1'b0;
            rsp_word.kind     = asw_pkg::KIND_DONE;
            rsp_word.unstable = 1'b1;
         end else if (idx_inc == timeout_tgt_ff) begin
            busy_in           = 1'b0;
            rsp_word.kind     = asw_pkg::KIND_DONE;
            rsp_word.value    = req_word.sample;
            rsp_word.unstable = 1'b1;
         end else begin
            if (idx_ff != '0) begin
               max_in = max_upd;
               min_in = min_upd;
            end
            run_in = run_upd;
            idx_in = idx_inc;
            pos_in = pos_inc;
            if (run_upd >= stable_tgt_ff) begin
               busy_in        = 1'b0;
               rsp_word.kind  = asw_pkg::KIND_DONE;
               rsp_word.value = req_word.sample;
            end else begin
               rsp_word.kind          = asw_pkg::KIND_FRAME;
               rsp_word.command_frame = frame_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         frame_ff       <= '0;
         max_ff         <= '0;
         min_ff         <= '0;
         idx_ff         <= '0;
         pos_ff         <= '0;
         run_ff         <= '0;
         stable_tgt_ff  <= '0;
         timeout_tgt_ff <= '0;
      end else if (accept) begin
         busy_ff        <= busy_in;
         frame_ff       <= frame_in;
         max_ff         <= max_in;
         min_ff         <= min_in;
         idx_ff         <= idx_in;
         pos_ff         <= pos_in;
         run_ff         <= run_in;
         stable_tgt_ff  <= stable_tgt_in;
         timeout_tgt_ff <= timeout_tgt_in;
      end
   end

`ifndef SYNTHESIS
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.req_type == asw_pkg::REQ_START && stable_windows_ff != '0
      |=> busy_ff)
      else $error("start word did not arm a run");

   a_idle_ignore: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.req_type == asw_pkg::REQ_SAMPLE && !busy_ff
      |-> rsp_word.kind == asw_pkg::KIND_IGNORED)
      else $error("sample while idle not ignored");

   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_word.kind == asw_pkg::KIND_DONE |=> !busy_ff)
      else $error("run still busy after done word");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> run_ff < stable_tgt_ff)
      else $error("stable count reached target without ending run");
`endif

endmodule

FILE: src/asw_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_out_buf
// Result register with a skid entry; input stall is a registered full flag.
// ----------------------------------------------------------------------------
module asw_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  asw_pkg::rsp_word_type push_word,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output asw_pkg::rsp_word_type rsp_word
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   asw_pkg::rsp_word_type out_word_ff, out_word_in;
   asw_pkg::rsp_word_type skid_word_ff, skid_word_in;
   logic                  out_free;

   always_comb begin
      out_free      = !out_valid_ff || !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("word pushed into full buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff && out_valid_ff)
      else $error("skid entry not moved forward");
`endif

endmodule

FILE: src/adc_settling_window_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_settling_window_detector_unit
// Settling detector: aligned-window min/max spread check per ADC sample word.
// ----------------------------------------------------------------------------
// The result word is registered in the output buffer, or held in its skid entry while the output stalls.
// Throughput: one word per cycle while req_stall is low; the run state updates in a single pass.
// req_stall rises only when the two-entry result buffer is full.
// Reset (synchronous): run idle, buffer empty, registers back to defaults.
module adc_settling_window_detector_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [asw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asw_pkg::DATA_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [3:0]                    req_channel,
   input  logic [7:0]                    req_multiplier,
   input  logic [asw_pkg::DATA_W-1:0]    req_sample,
   input  logic                          req_transfer_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [asw_pkg::DATA_W-1:0]    rsp_command_frame,
   output logic [asw_pkg::DATA_W-1:0]    rsp_value,
   output logic                          rsp_unstable
);

   asw_pkg::req_word_type req_word;
   asw_pkg::rsp_word_type core_word;
   asw_pkg::rsp_word_type out_word;
   logic                  accept;
   logic                  buf_full;

   assign req_word.req_type    = req_type;
   assign req_word.channel     = req_channel;
   assign req_word.multiplier  = req_multiplier;
   assign req_word.sample      = req_sample;
   assign req_word.transfer_ok = req_transfer_ok;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   asw_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_word         (req_word),
      .rsp_word         (core_word)
   );

   asw_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (core_word),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (out_word)
   );

   assign rsp_kind          = out_word.kind;
   assign rsp_command_frame = out_word.command_frame;
   assign rsp_value         = out_word.value;
   assign rsp_unstable      = out_word.unstable;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC settling window detector. A queue-fed
// driver offers start and sample words with random gaps. A cycle-accurate
// predictor computes the expected result word for each accepted word, and
// a monitor checks the result words field by field while stalling at random.
// Register settings are changed between phases, once all words have drained.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [asw_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [asw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [asw_pkg::DATA_W-1:0]    csr_write_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_type = asw_pkg::REQ_START;
   logic [3:0]                    req_channel = '0;
   logic [7:0]                    req_multiplier = '0;
   logic [asw_pkg::DATA_W-1:0]    req_sample = '0;
   logic                          req_transfer_ok = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_kind;
   logic [asw_pkg::DATA_W-1:0]    rsp_command_frame;
   logic [asw_pkg::DATA_W-1:0]    rsp_value;
   logic                          rsp_unstable;

   adc_settling_window_detector_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_channel       (req_channel),
      .req_multiplier    (req_multiplier),
      .req_sample        (req_sample),
      .req_transfer_ok   (req_transfer_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_command_frame (rsp_command_frame),
      .rsp_value         (rsp_value),
      .rsp_unstable      (rsp_unstable)
   );

   always #10 clock = ~clock;

   // predictor copy of registers and run state
   logic [asw_pkg::DATA_W-1:0] cfg_range;
   logic [asw_pkg::DATA_W-1:0] cfg_windows;
   logic [asw_pkg::DATA_W-1:0] cfg_timeout;
   logic                       run_active;
   logic [asw_pkg::DATA_W-1:0] run_frame;
   logic [asw_pkg::DATA_W-1:0] win_hi;
   logic [asw_pkg::DATA_W-1:0] win_lo;
   logic [asw_pkg::CNT_W-1:0]  run_index;
   logic [asw_pkg::CNT_W-1:0]  settled_count;
   logic [asw_pkg::CNT_W-1:0]  settle_goal;
   logic [asw_pkg::CNT_W-1:0]  timeout_goal;

   asw_pkg::req_word_type pending_req_q[$];
   asw_pkg::rsp_word_type expected_rsp_q[$];
   asw_pkg::req_word_type drv_word;

   int          error_count = 0;
   bit          src_idle_mode = 1'b1;
   bit          sink_idle_mode = 1'b1;
   int          src_gap_left = 0;
   int          sink_gap_left = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   logic [15:0] gen_range = asw_pkg::RST_STABLE_RANGE;

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR %0t: %0s", $time, msg);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic reset_model();
      cfg_range     = asw_pkg::RST_STABLE_RANGE;
      cfg_windows   = asw_pkg::RST_STABLE_WINDOWS;
      cfg_timeout   = asw_pkg::RST_TIMEOUT;
      run_active    = 1'b0;
      run_frame     = '0;
      win_hi        = '0;
      win_lo        = '0;
      run_index     = '0;
      settled_count = '0;
      settle_goal   = '0;
      timeout_goal  = '0;
   endtask

   function automatic asw_pkg::rsp_word_type predict_settling(input asw_pkg::req_word_type w);
      asw_pkg::rsp_word_type r;
      logic [asw_pkg::CNT_W-1:0] mul;
      r = '0;
      r.kind = asw_pkg::KIND_FRAME;
      if (w.req_type == asw_pkg::REQ_START) begin
         mul = (w.multiplier == 8'd0) ? asw_pkg::CNT_W'(1) : asw_pkg::CNT_W'(w.multiplier);
         run_frame     = asw_pkg::FRAME_BASE | (asw_pkg::DATA_W'(w.channel) << 7);
         win_hi        = '0;
         win_lo        = '0;
         run_index     = '0;
         settled_count = '0;
         settle_goal   = mul * asw_pkg::CNT_W'(cfg_windows);
         timeout_goal  = mul * asw_pkg::CNT_W'(cfg_timeout);
         if (settle_goal == '0) begin
            run_active = 1'b0;
            r.kind = asw_pkg::KIND_DONE;
         end else begin
            run_active = 1'b1;
            r.command_frame = run_frame;
         end
      end else if (!run_active) begin
         r.kind = asw_pkg::KIND_IGNORED;
      end else if (!w.transfer_ok) begin
         run_active = 1'b0;
         r.kind = asw_pkg::KIND_DONE;
         r.unstable = 1'b1;
      end else if (run_index == timeout_goal - asw_pkg::CNT_W'(1)) begin
         run_active = 1'b0;
         r.kind = asw_pkg::KIND_DONE;
         r.value = w.sample;
         r.unstable = 1'b1;
      end else begin
         if (run_index != '0) begin
            if (run_index % asw_pkg::CNT_W'(asw_pkg::WINDOW_LEN) == asw_pkg::CNT_W'(1)) begin
               win_hi = w.sample;
               win_lo = w.sample;
            end else begin
               if (w.sample > win_hi) win_hi = w.sample;
               if (w.sample < win_lo) win_lo = w.sample;
            end
            if (run_index % asw_pkg::CNT_W'(asw_pkg::WINDOW_LEN) == '0) begin
               if (32'(win_hi) - 32'(win_lo) < 32'(cfg_range)) begin
                  if (settled_count != asw_pkg::CNT_MAX) settled_count++;
               end else begin
                  settled_count = '0;
               end
            end
         end
         run_index = run_index + asw_pkg::CNT_W'(1);
         if (settled_count >= settle_goal) begin
            run_active = 1'b0;
            r.kind = asw_pkg::KIND_DONE;
            r.value = w.sample;
         end else begin
            r.command_frame = run_frame;
         end
      end
      return r;
   endfunction

   task automatic push_start(input logic [3:0] ch, input logic [7:0] mul);
      asw_pkg::req_word_type w;
      w.req_type    = asw_pkg::REQ_START;
      w.channel     = ch;
      w.multiplier  = mul;
      w.sample      = asw_pkg::DATA_W'($urandom);
      w.transfer_ok = 1'($urandom);
      pending_req_q.push_back(w);
   endtask

   task automatic push_sample(input logic [asw_pkg::DATA_W-1:0] s, input logic ok);
      asw_pkg::req_word_type w;
      w.req_type    = asw_pkg::REQ_SAMPLE;
      w.channel     = 4'($urandom);
      w.multiplier  = 8'($urandom);
      w.sample      = s;
      w.transfer_ok = ok;
      pending_req_q.push_back(w);
   endtask

   // runs: start, then samples around a level, sometimes noisy first, with stray words
   task automatic gen_runs(input int n_items);
      int count;
      int len;
      int base;
      int amp;
      int noisy;
      int v;
      int k;
      int r;
      logic [7:0] mul;
      count = 0;
      while (count < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 55) mul = 8'($urandom_range(0, 2));
         else if (r < 85) mul = 8'($urandom_range(3, 4));
         else if (r < 93) mul = 8'd255;
         else mul = 8'($urandom_range(0, 255));
         push_start(4'($urandom_range(0, 15)), mul);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(3, 60);
         if (len > n_items - count - 1) len = n_items - count - 1;
         base = $urandom_range(0, 65535);
         if ($urandom_range(0, 9) < 6) amp = (gen_range > 1) ? (int'(gen_range) - 1) / 2 : 0;
         else amp = $urandom_range(0, 65535);
         noisy = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 20) : 0;
         for (k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               push_sample(asw_pkg::DATA_W'($urandom), 1'b0);
            end else if (r < 6) begin
               if ($urandom_range(0, 1) == 0) begin
                  push_sample(asw_pkg::DATA_W'($urandom), 1'($urandom));
               end else begin
                  push_start(4'($urandom), 8'($urandom));
               end
            end else begin
               if (k < noisy) v = $urandom_range(0, 65535);
               else v = base - amp + int'($urandom_range(0, 2 * amp));
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               push_sample(asw_pkg::DATA_W'(v), 1'b1);
            end
         end
         count += len + 1;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [asw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [asw_pkg::DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         asw_pkg::CSR_STABLE_RANGE:   cfg_range   = data;
         asw_pkg::CSR_STABLE_WINDOWS: cfg_windows = data;
         asw_pkg::CSR_TIMEOUT:        cfg_timeout = data;
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [15:0] rng, input logic [15:0] win,
                            input logic [15:0] tmo, input int n_items,
                            input bit src_on, input bit sink_on, input int hold);
      write_csr(asw_pkg::CSR_STABLE_RANGE, rng);
      write_csr(asw_pkg::CSR_STABLE_WINDOWS, win);
      write_csr(asw_pkg::CSR_TIMEOUT, tmo);
      gen_range      = rng;
      src_idle_mode  = src_on;
      sink_idle_mode = sink_on;
      gen_runs(n_items);
      @(negedge clock);
      hold_request = hold;
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(predict_settling(drv_word));
            nxt_valid = 1'b0;
            src_gap_left = src_idle_mode ? pick_gap() : 0;
         end
         if (!nxt_valid) begin
            if (src_gap_left > 0) begin
               src_gap_left--;
            end else if (pending_req_q.size() != 0) begin
               drv_word = pending_req_q.pop_front();
               req_type        <= drv_word.req_type;
               req_channel     <= drv_word.channel;
               req_multiplier  <= drv_word.multiplier;
               req_sample      <= drv_word.sample;
               req_transfer_ok <= drv_word.transfer_ok;
               nxt_valid = 1'b1;
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin : rsp_monitor
      asw_pkg::rsp_word_type exp_w;
      logic nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_error("result word with nothing outstanding");
            end else begin
               exp_w = expected_rsp_q.pop_front();
               if (rsp_kind !== exp_w.kind)
                  report_error($sformatf("kind got %0d want %0d", rsp_kind, exp_w.kind));
               if (rsp_command_frame !== exp_w.command_frame)
                  report_error($sformatf("command_frame got %h want %h",
                                         rsp_command_frame, exp_w.command_frame));
               if (rsp_value !== exp_w.value)
                  report_error($sformatf("value got %h want %h", rsp_value, exp_w.value));
               if (rsp_unstable !== exp_w.unstable)
                  report_error($sformatf("unstable got %b want %b",
                                         rsp_unstable, exp_w.unstable));
            end
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end else if (sink_gap_left > 0) begin
            sink_gap_left--;
            nxt_stall = 1'b1;
         end else begin
            nxt_stall = 1'b0;
            if (sink_idle_mode && $urandom_range(0, 3) == 0) sink_gap_left = pick_gap();
         end
         rsp_stall <= nxt_stall;
      end
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int i;
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle samples, bus error, restart while busy
      push_sample(16'hFFFF, 1'b1);
      push_sample(16'h0000, 1'b0);
      push_start(4'd15, 8'd0);
      push_sample(16'h1234, 1'b0);
      push_start(4'd0, 8'd255);
      push_start(4'd10, 8'd1);
      push_sample(16'h0000, 1'b1);
      push_sample(16'hFFFF, 1'b1);
      wait_drained();

      // widest range, no timeout: settles on the first full window
      write_csr(asw_pkg::CSR_STABLE_RANGE, 16'hFFFF);
      write_csr(asw_pkg::CSR_STABLE_WINDOWS, 16'd1);
      write_csr(asw_pkg::CSR_TIMEOUT, 16'd0);
      push_start(4'd5, 8'd1);
      push_sample(16'h0000, 1'b1);
      for (i = 0; i < 8; i++) push_sample(i[0] ? 16'hFFFE : 16'h0000, 1'b1);
      wait_drained();

      // zero stable target ends at start; unused register index
      write_csr(asw_pkg::CSR_STABLE_RANGE, 16'd0);
      write_csr(asw_pkg::CSR_STABLE_WINDOWS, 16'd0);
      write_csr(asw_pkg::CSR_TIMEOUT, 16'd1);
      write_csr(CSR_SPARE, asw_pkg::DATA_W'($urandom));
      push_start(4'd3, 8'd2);
      push_sample(16'h00FF, 1'b1);
      wait_drained();

      // timeout on the very first sample
      write_csr(asw_pkg::CSR_STABLE_WINDOWS, 16'hFFFF);
      push_start(4'd7, 8'd1);
      push_sample(16'h8000, 1'b1);
      wait_drained();

      run_phase(asw_pkg::RST_STABLE_RANGE, asw_pkg::RST_STABLE_WINDOWS, asw_pkg::RST_TIMEOUT,
                150, 1'b1, 1'b1, 0);
      run_phase(16'd200, 16'd2, 16'd60, 120, 1'b0, 1'b0, 0);
      run_phase(16'hFFFF, 16'd1, 16'd30, 120, 1'b0, 1'b1, 80);
      run_phase(16'd8, 16'd1, 16'd0, 120, 1'b1, 1'b1, 0);
      run_phase(16'd0, 16'd3, 16'd1, 60, 1'b1, 1'b0, 0);
      run_phase(16'($urandom_range(0, 400)), 16'($urandom_range(1, 3)),
                16'($urandom_range(16, 120)), 120, 1'b0, 1'b1, 120);
      run_phase(16'd300, 16'hFFFF, 16'hFFFF, 60, 1'b1, 1'b1, 0);
      run_phase(asw_pkg::RST_STABLE_RANGE, asw_pkg::RST_STABLE_WINDOWS, asw_pkg::RST_TIMEOUT,
                60, 1'b1, 1'b1, 0);

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
